// ===== rtl/lcg_arw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_arw_pkg
// shared constants and types for the alternating-threshold random walk
// ----------------------------------------------------------------------------
package lcg_arw_pkg;

	// generator arithmetic
	localparam int unsigned STATE_WIDTH = 64;
	localparam int unsigned WORD_WIDTH  = 61;

	localparam logic [STATE_WIDTH-1:0] LCG_MUL   = 64'd3125;
	localparam logic [STATE_WIDTH-1:0] LCG_INC   = 64'd16807;
	localparam logic [STATE_WIDTH-1:0] MODULUS64 = 64'd1944674407370955169;
	localparam logic [WORD_WIDTH-1:0]  MODULUS   = MODULUS64[WORD_WIDTH-1:0];

	// largest multiple count of the modulus that fits in the state word
	localparam int unsigned QMAX = int'(64'hFFFF_FFFF_FFFF_FFFF / MODULUS64);

	// walker
	localparam int unsigned POSITION_WIDTH_DEFAULT = 32;
	localparam int unsigned OUT_POS_WIDTH          = 32;

	// register reset values
	localparam logic [STATE_WIDTH-1:0]   SEED_RESET      = 64'd1;
	localparam logic [OUT_POS_WIDTH-1:0] START_RESET     = 32'd0;
	localparam logic [WORD_WIDTH-1:0]    THRESHOLD_RESET = 61'd972337203685477584;

	// configuration register map
	localparam int unsigned CFG_INDEX_WIDTH = 2;
	localparam int unsigned CFG_DATA_WIDTH  = 64;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_SEED      = 2'd0,
		REG_START     = 2'd1,
		REG_THRESHOLD = 2'd2
	} cfg_reg_t;

endpackage

// ===== rtl/lcg_arw_lcg.sv =====
// ----------------------------------------------------------------------------
// lcg_arw_lcg
// one generator step: 64-bit wrapping multiply-add, then reduction by the modulus
// ----------------------------------------------------------------------------
module lcg_arw_lcg (
	input  logic [lcg_arw_pkg::STATE_WIDTH-1:0] state,
	output logic [lcg_arw_pkg::WORD_WIDTH-1:0]  next_word
);

	logic [lcg_arw_pkg::STATE_WIDTH-1:0] mac;
	logic [lcg_arw_pkg::QMAX-1:0]        ge;
	logic [lcg_arw_pkg::STATE_WIDTH-1:0] diff [lcg_arw_pkg::QMAX];
	logic [lcg_arw_pkg::STATE_WIDTH-1:0] reduced;

	// constant multiply wraps at 64 bits like the unsigned arithmetic it mirrors
	assign mac = state * lcg_arw_pkg::LCG_MUL + lcg_arw_pkg::LCG_INC;

	// compare against every multiple of the modulus in parallel
	for (genvar k = 0; k < lcg_arw_pkg::QMAX; k++) begin : g_mult
		localparam logic [lcg_arw_pkg::STATE_WIDTH-1:0] KM =
			lcg_arw_pkg::MODULUS64 * 64'(k + 1);
		assign ge[k]   = (mac >= KM);
		assign diff[k] = mac - KM;
	end

	// highest multiple not above the value wins
	always_comb begin
		reduced = mac;
		for (int k = 0; k < lcg_arw_pkg::QMAX; k++) begin
			if (ge[k]) begin
				reduced = diff[k];
			end
		end
	end

	assign next_word = reduced[lcg_arw_pkg::WORD_WIDTH-1:0];

endmodule

// ===== rtl/lcg_arw_walk.sv =====
// ----------------------------------------------------------------------------
// lcg_arw_walk
// threshold selection, step direction and next walker position
// ----------------------------------------------------------------------------
module lcg_arw_walk #(
	parameter int unsigned POSITION_WIDTH = lcg_arw_pkg::POSITION_WIDTH_DEFAULT
) (
	input  logic                                  restart,
	input  logic                                  phase,
	input  logic [lcg_arw_pkg::WORD_WIDTH-1:0]    word,
	input  logic [lcg_arw_pkg::WORD_WIDTH-1:0]    threshold,
	input  logic [lcg_arw_pkg::OUT_POS_WIDTH-1:0] start,
	input  logic [POSITION_WIDTH-1:0]             pos,
	output logic [POSITION_WIDTH-1:0]             pos_next,
	output logic                                  moved_right
);

	localparam int unsigned OPW = lcg_arw_pkg::OUT_POS_WIDTH;

	logic [lcg_arw_pkg::WORD_WIDTH-1:0] thr_sat;
	logic [lcg_arw_pkg::WORD_WIDTH-1:0] thr;
	logic                               right;
	logic [POSITION_WIDTH-1:0]          start_ext;

	// threshold above the modulus saturates, odd phase uses the complement
	assign thr_sat = (threshold > lcg_arw_pkg::MODULUS) ? lcg_arw_pkg::MODULUS : threshold;
	assign thr     = phase ? (lcg_arw_pkg::MODULUS - thr_sat) : thr_sat;
	assign right   = (word < thr);

	// start position sign-extended or truncated to the walker width
	if (POSITION_WIDTH > OPW) begin : g_start_wide
		assign start_ext = {{(POSITION_WIDTH - OPW){start[OPW-1]}}, start};
	end else begin : g_start_narrow
		assign start_ext = start[POSITION_WIDTH-1:0];
	end

	always_comb begin
		if (restart) begin
			pos_next = start_ext;
		end else if (right) begin
			pos_next = pos + POSITION_WIDTH'(1);
		end else begin
			pos_next = pos - POSITION_WIDTH'(1);
		end
	end

	assign moved_right = right & ~restart;

endmodule

// ===== rtl/lcg_alternating_random_walk_top.sv =====
// ----------------------------------------------------------------------------
// lcg_alternating_random_walk_top
// one-dimensional random walk driven by a linear congruential generator
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall / restart): each transfer is one item,
//   restart=1 reloads the start position, restart=0 takes one step.
//   output channel (out_valid / out_stall / position, moved_right, stepped,
//   random_word): exactly one result per input item, in order.
//   config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
//   is always high; write only while the block is idle. index 0 loads the
//   seed straight into the generator, 1 sets the start position, 2 sets the
//   right-step threshold, other indexes are ignored.
// timing:
//   the generator step, threshold compare and position update are combinational
//   from the input register into the result register. an input transfer fills
//   the input register, its result then the result register, which drives
//   out_valid. throughput is one item per cycle while out_stall is low.
// reset:
//   arst_n clears both valids, seed 1 in the generator, phase 0, position 0.
// backpressure:
//   out_stall holds the result register; the input register then fills and
//   in_stall rises until the result is taken. nothing is dropped.
// ----------------------------------------------------------------------------
module lcg_alternating_random_walk_top #(
	parameter int unsigned POSITION_WIDTH = lcg_arw_pkg::POSITION_WIDTH_DEFAULT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,

	// input items
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic                                    restart,

	// result items
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [lcg_arw_pkg::OUT_POS_WIDTH-1:0]   position,
	output logic                                    moved_right,
	output logic                                    stepped,
	output logic [lcg_arw_pkg::WORD_WIDTH-1:0]      random_word,

	// configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lcg_arw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [lcg_arw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int unsigned SW  = lcg_arw_pkg::STATE_WIDTH;
	localparam int unsigned WW  = lcg_arw_pkg::WORD_WIDTH;
	localparam int unsigned OPW = lcg_arw_pkg::OUT_POS_WIDTH;

	// config registers
	logic [OPW-1:0]            start_q;
	logic [WW-1:0]             threshold_q;

	// walk state
	logic [SW-1:0]             gen_state_q;
	logic                      phase_q;
	logic [POSITION_WIDTH-1:0] pos_q;

	// input register
	logic                      valid_s1;
	logic                      restart_s1;

	// result register
	logic                      valid_s2;
	logic [OPW-1:0]            position_s2;
	logic                      moved_right_s2;
	logic                      stepped_s2;
	logic [WW-1:0]             random_word_s2;

	// datapath
	logic [WW-1:0]             next_word;
	logic [POSITION_WIDTH-1:0] pos_next;
	logic                      right;
	logic [WW-1:0]             word;
	logic [OPW-1:0]            pos_out;

	// handshake
	logic                      advance_s1;
	logic                      fire_s1;
	logic                      take_in;

	// result register frees when empty or when its result leaves this cycle
	assign advance_s1 = ~valid_s2 | ~out_stall;
	assign fire_s1    = valid_s1 & advance_s1;
	assign take_in    = in_valid & ~in_stall;
	assign in_stall   = valid_s1 & ~advance_s1;
	assign cfg_ready  = 1'b1;

	lcg_arw_lcg u_lcg (
		.state     (gen_state_q),
		.next_word (next_word)
	);

	// restart reports the current state, a step reports the new one
	assign word = restart_s1 ? gen_state_q[WW-1:0] : next_word;

	lcg_arw_walk #(
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_walk (
		.restart     (restart_s1),
		.phase       (phase_q),
		.word        (next_word),
		.threshold   (threshold_q),
		.start       (start_q),
		.pos         (pos_q),
		.pos_next    (pos_next),
		.moved_right (right)
	);

	// reported position is the low bits of the walker, zero-filled if narrower
	if (POSITION_WIDTH >= OPW) begin : g_pos_wide
		assign pos_out = pos_next[OPW-1:0];
	end else begin : g_pos_narrow
		assign pos_out = {{(OPW - POSITION_WIDTH){1'b0}}, pos_next};
	end

	// walk state and config; the user must write config only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= lcg_arw_pkg::SEED_RESET;
			phase_q     <= 1'b0;
			pos_q       <= '0;
			start_q     <= lcg_arw_pkg::START_RESET;
			threshold_q <= lcg_arw_pkg::THRESHOLD_RESET;
		end else begin
			if (fire_s1) begin
				pos_q <= pos_next;
				if (!restart_s1) begin
					gen_state_q <= {{(SW - WW){1'b0}}, next_word};
					phase_q     <= ~phase_q;
				end
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					lcg_arw_pkg::REG_SEED: begin
						gen_state_q <= cfg_data;
					end
					lcg_arw_pkg::REG_START: begin
						start_q <= cfg_data[OPW-1:0];
					end
					lcg_arw_pkg::REG_THRESHOLD: begin
						threshold_q <= cfg_data[WW-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			restart_s1 <= restart;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			position_s2    <= pos_out;
			moved_right_s2 <= right;
			stepped_s2     <= ~restart_s1;
			random_word_s2 <= word;
		end
	end

	assign out_valid   = valid_s2;
	assign position    = position_s2;
	assign moved_right = moved_right_s2;
	assign stepped     = stepped_s2;
	assign random_word = random_word_s2;

endmodule

// ===== tb/sv/lcg_arw_checker.sv =====
// ----------------------------------------------------------------------------
// lcg_arw_checker
// watches the item, result and register channels of the random walk, keeps
// its own walker and generator, and compares every result transfer in order
// ----------------------------------------------------------------------------
module lcg_arw_checker
	import lcg_arw_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       restart,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [OUT_POS_WIDTH-1:0]   position,
	input  logic                       moved_right,
	input  logic                       stepped,
	input  logic [WORD_WIDTH-1:0]      random_word,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	output int                         mismatch_count,
	output int                         results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] WALK_MUL = 64'd3125;
	localparam logic [63:0] WALK_INC = 64'd16807;
	localparam logic [63:0] WALK_MOD = 64'd1944674407370955169;

	typedef struct packed {
		logic [31:0] position;
		logic        moved_right;
		logic        stepped;
		logic [60:0] random_word;
	} walk_result_t;

	walk_result_t expected_walk[$];

	// register copies and walker state
	logic [31:0] start_reg;
	logic [60:0] thresh_reg;
	logic [63:0] gen_state;
	logic        thr_phase;
	logic [31:0] walker_pos;

	// advances the walker by one item and returns what the block should report
	function automatic walk_result_t walk_item(input logic reload);
		walk_result_t r;
		logic [63:0]  thr;
		logic [63:0]  mixed;
		r = '0;
		if (reload) begin
			walker_pos    = start_reg;
			r.random_word = gen_state[60:0];
		end else begin
			thr = ({3'b000, thresh_reg} > WALK_MOD) ? WALK_MOD : {3'b000, thresh_reg};
			if (thr_phase)
				thr = WALK_MOD - thr;
			mixed         = WALK_MUL * gen_state + WALK_INC;
			gen_state     = mixed % WALK_MOD;
			r.moved_right = (gen_state < thr);
			walker_pos    = r.moved_right ? walker_pos + 32'd1 : walker_pos - 32'd1;
			thr_phase     = ~thr_phase;
			r.stepped     = 1'b1;
			r.random_word = gen_state[60:0];
		end
		r.position = walker_pos;
		return r;
	endfunction

	task automatic report_fail(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		walk_result_t got;
		walk_result_t want;
		if (!arst_n) begin
			start_reg       = 32'd0;
			thresh_reg      = 61'd972337203685477584;
			gen_state       = 64'd1;
			thr_phase       = 1'b0;
			walker_pos      = 32'd0;
			expected_walk.delete();
			mismatch_count  = 0;
			results_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{position, moved_right, stepped, random_word};
				if (expected_walk.size() == 0) begin
					report_fail($sformatf({"%0t: result with none expected: ",
						"pos=%0d right=%0b step=%0b word=%0d"},
						$realtime, $signed(got.position), got.moved_right, got.stepped,
						got.random_word));
				end else begin
					want = expected_walk.pop_front();
					if (got.position !== want.position || got.moved_right !== want.moved_right ||
					    got.stepped !== want.stepped || got.random_word !== want.random_word)
						report_fail($sformatf({"%0t: walk mismatch: expected pos=%0d right=%0b step=%0b ",
							"word=%0d, got pos=%0d right=%0b step=%0b word=%0d"}, $realtime,
							$signed(want.position), want.moved_right, want.stepped, want.random_word,
							$signed(got.position), got.moved_right, got.stepped, got.random_word));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_SEED:      gen_state  = cfg_data;
					REG_START:     start_reg  = cfg_data[31:0];
					REG_THRESHOLD: thresh_reg = cfg_data[60:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_walk.push_back(walk_item(restart));
			results_pending = expected_walk.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives step and restart items through the random walk under bursty input
// and patterned output backpressure, rewrites seed, start position and
// threshold between phases, and reports the checker's verdict
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lcg_arw_pkg::*;

	// index with no register behind it, the block must ignore writes to it
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_NONE = 2'd3;

	// cycles without any transfer before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// receiver hold-off length for the fill-up test
	localparam int HOLD_CYCLES = 200;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic                       restart     = 1'b0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic [OUT_POS_WIDTH-1:0]   position;
	logic                       moved_right;
	logic                       stepped;
	logic [WORD_WIDTH-1:0]      random_word;
	logic                       cfg_valid   = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data    = '0;

	int fail_count;
	int results_pending;

	// sender burst shaping, changed per phase
	int burst_left = 0;
	int burst_max  = 8;
	int gap_max    = 4;

	// set by the stimulus to ask the receiver for one long hold-off
	bit hold_req = 1'b0;

	lcg_alternating_random_walk_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.moved_right (moved_right),
		.stepped     (stepped),
		.random_word (random_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	lcg_arw_checker walk_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.position        (position),
		.moved_right     (moved_right),
		.stepped         (stepped),
		.random_word     (random_word),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatch_count  (fail_count),
		.results_pending (results_pending)
	);

	// 2 ns clock
	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog: any transfer on any channel restarts the idle count
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// receiver: runs of random length, each with its own stall density,
	// plus one long hold-off on request
	initial begin
		int run_left;
		int stall_pct;
		run_left  = 0;
		stall_pct = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				// counted here so the sender keeps offering items meanwhile
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				if (run_left == 0) begin
					run_left = $urandom_range(20, 120);
					case ($urandom_range(0, 4))
						0, 1:    stall_pct = 0;
						2:       stall_pct = 25;
						3:       stall_pct = 50;
						default: stall_pct = 80;
					endcase
				end
				run_left--;
				out_stall <= ($urandom_range(1, 100) <= stall_pct);
			end
		end
	end

	// one item transfer; entered and left at a falling edge. valid stays
	// high inside a burst and drops only when the burst runs out
	task automatic send_item(input logic reload);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, gap_max);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, burst_max);
		end
		in_valid <= 1'b1;
		restart  <= reload;
		burst_left--;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (burst_left == 0)
			in_valid <= 1'b0;
	endtask

	// cut the current burst short and let every pending result come out
	task automatic drain;
		if (burst_left != 0) begin
			in_valid  <= 1'b0;
			burst_left = 0;
		end
		while (results_pending != 0) @(negedge clk);
		// two-stage pipe, the extra wait leaves it surely empty
		repeat (4) @(negedge clk);
	endtask

	// register write; only called after drain
	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
	                         input logic [CFG_DATA_WIDTH-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int n_items;
		int restart_pct;
		logic [63:0] rnd;

		// reset held low first, then released away from the rising edge
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// ---------------- directed part ----------------
		// reset settings: restart shows the reset seed, then plain steps
		send_item(1'b1);
		repeat (3) send_item(1'b0);

		// zero seed, top start position, threshold saturated above the modulus:
		// the walk alternates left/right from the odd phase, so it reaches the positive limit without wrapping
		drain();
		write_reg(REG_SEED, 64'd0);
		write_reg(REG_START, {32'hFFFF_FFFF, 32'h7FFF_FFFF});
		write_reg(REG_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(1'b1);
		repeat (3) send_item(1'b0);

		// unreduced all-ones seed reported by restart, bottom start position,
		// zero threshold wraps across the negative limit
		drain();
		write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_START, {32'h0, 32'h8000_0000});
		write_reg(REG_THRESHOLD, 64'd0);
		send_item(1'b1);
		repeat (3) send_item(1'b0);

		// seed equal to the modulus, threshold exactly the modulus,
		// and a write to the unused index that must change nothing
		drain();
		write_reg(REG_SEED, MODULUS64);
		write_reg(REG_THRESHOLD, MODULUS64);
		write_reg(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(REG_START, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(1'b1);
		repeat (2) send_item(1'b0);

		// one below the modulus, back-to-back restarts keep the generator
		drain();
		write_reg(REG_THRESHOLD, MODULUS64 - 64'd1);
		write_reg(REG_SEED, MODULUS64 - 64'd1);
		repeat (2) send_item(1'b0);
		repeat (2) send_item(1'b1);

		drain();
		write_reg(REG_THRESHOLD, 64'd1);
		repeat (2) send_item(1'b0);

		// ---------------- random part ----------------
		for (int phase = 0; phase < 12; phase++) begin
			drain();

			// new settings, each register rewritten with some chance
			if ($urandom_range(0, 9) < 6) begin
				rnd = {$urandom, $urandom};
				case ($urandom_range(0, 4))
					0:       write_reg(REG_SEED, rnd);
					1:       write_reg(REG_SEED, rnd % MODULUS64);
					2:       write_reg(REG_SEED, 64'd0);
					3:       write_reg(REG_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
					default: write_reg(REG_SEED, 64'($urandom_range(0, 1000)));
				endcase
			end
			if ($urandom_range(0, 9) < 6) begin
				rnd = {$urandom, $urandom};
				case ($urandom_range(0, 3))
					0:       write_reg(REG_START, rnd);
					1:       write_reg(REG_START, {rnd[63:32], 32'h7FFF_FFFF});
					2:       write_reg(REG_START, {rnd[63:32], 32'h8000_0000});
					default: write_reg(REG_START, {rnd[63:32], 32'($urandom_range(0, 20)) - 32'd10});
				endcase
			end
			if ($urandom_range(0, 9) < 6) begin
				rnd = {$urandom, $urandom};
				case ($urandom_range(0, 5))
					0:       write_reg(REG_THRESHOLD, rnd);
					1, 2:    write_reg(REG_THRESHOLD, {rnd[63:61], 61'(rnd % MODULUS64)});
					3:       write_reg(REG_THRESHOLD, 64'd0);
					4:       write_reg(REG_THRESHOLD, MODULUS64);
					default: write_reg(REG_THRESHOLD, {rnd[63:61], 61'h1FFF_FFFF_FFFF_FFFF});
				endcase
			end
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_NONE, {$urandom, $urandom});

			// mostly long walks with rare restarts, sometimes restart-heavy noise
			case ($urandom_range(0, 3))
				0, 1:    restart_pct = 3;
				2:       restart_pct = 10;
				default: restart_pct = 50;
			endcase

			// sender shape: bursty, or a long stretch with no idling
			if (phase % 4 == 2) begin
				burst_max = 400;
				gap_max   = 1;
			end else begin
				burst_max = $urandom_range(1, 16);
				gap_max   = $urandom_range(1, 8);
			end

			// long receiver hold-off while items keep coming, so the
			// input side fills and stalls
			if (phase == 3)
				hold_req = 1'b1;

			n_items = $urandom_range(85, 105);
			for (int k = 0; k < n_items; k++) begin
				// once mid-run the sender waits for every result to arrive
				if (phase == 6 && k == n_items / 2)
					drain();
				send_item($urandom_range(0, 99) < restart_pct);
			end
		end

		// let everything come out, then the verdict
		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && results_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
